FILE: src/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types and constants of the padded decimal formatter
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int DEF_FIELD_DIGITS = 20;
    localparam int DEF_VALUE_WIDTH  = 64;
    localparam int RESULT_LIMIT     = 20;
    localparam int BCD_DIGITS       = 20;
    localparam int BCD_W            = 4 * BCD_DIGITS;
    localparam int IN_DATA_W        = 64;
    localparam int OUT_DATA_W       = 8;
    localparam int CHAR_W           = 6;
    localparam int WIDTH_W          = 5;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [WIDTH_W-1:0] PAD_WIDTH_RESET = 5'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO       = 6'd48;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             err;
    } pdf_entry_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

endpackage

FILE: src/padded_decimal_formatter.sv
// an accepted value passes the bcd converter, the queue, the entry and output registers
// the converter takes no new value until it has pushed the last one to the queue
// characters leave one a cycle under m_axis_tready, overlapping the next conversion
// reset: asynchronous, active low; clears queue and control, pad_width back to 10
// ----------------------------------------------------------------------------
// padded_decimal_formatter
// binary to zero-padded ascii decimal, most significant character first
// ----------------------------------------------------------------------------
module padded_decimal_formatter
    import pdf_pkg::*;
#(
    parameter int FIELD_DIGITS = DEF_FIELD_DIGITS,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [WIDTH_W-1:0]    cfg_wdata,      // pad_width
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // digit_char, zero fill
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser    // too_wide
);

    localparam int LIMIT = (FIELD_DIGITS < RESULT_LIMIT) ? FIELD_DIGITS : RESULT_LIMIT;

    logic [WIDTH_W-1:0] pad_width_reg;
    logic [WIDTH_W-1:0] eff_width;
    logic               push_valid;
    logic               push_ready;
    pdf_entry_t         push_entry;
    logic               pop_valid;
    logic               pop_ready;
    pdf_entry_t         pop_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_width_reg <= PAD_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            pad_width_reg <= cfg_wdata;
        end
    end

    assign eff_width = (pad_width_reg > WIDTH_W'(LIMIT)) ? WIDTH_W'(LIMIT) : pad_width_reg;

    pdf_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .width         (eff_width),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    pdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    pdf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .width         (eff_width),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    // error word is always a single, empty word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("error word not last or not empty");

    // ordinary words carry an ascii digit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata >= OUT_DATA_W'(48) && m_axis_tdata <= OUT_DATA_W'(57))
        else $error("character out of digit range");

    // a value is taken only when the converter is free
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("converter took a second value while busy");
`endif

endmodule

FILE: src/pdf_front.sv
// ----------------------------------------------------------------------------
// pdf_front
// takes a value, converts it to bcd one bit a cycle and flags a too-wide field
// ----------------------------------------------------------------------------
module pdf_front
    import pdf_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [WIDTH_W-1:0]   width,
    output logic                 push_valid,
    input  logic                 push_ready,
    output pdf_entry_t           push_entry
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    front_state_t           state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       adj_bcd;
    logic                   err;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        push_valid    = 1'b0;
        unique case (state_reg)
            F_IDLE:  s_axis_tready = 1'b1;
            F_PUSH:  push_valid    = 1'b1;
            default: ;
        endcase
    end

    // add three to every digit of five or more, then shift in one bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adj_bcd[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj_bcd[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (state_reg == F_IDLE && s_axis_tvalid)
        begin
            cnt_next   = CNT_W'(VALUE_WIDTH);
            shift_next = s_axis_tdata[VALUE_WIDTH-1:0];
            bcd_next   = '0;
        end
        else if (state_reg == F_CONV)
        begin
            cnt_next   = cnt_reg - CNT_W'(1);
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_next   = {adj_bcd[BCD_W-2:0], shift_reg[VALUE_WIDTH-1]};
        end
    end

    // any significant digit at or above the field width, or a zero width, is an error
    always_comb
    begin
        err = (width == '0);
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0 && WIDTH_W'(i) >= width)
            begin
                err = 1'b1;
            end
        end
    end

    assign push_entry.bcd = bcd_reg;
    assign push_entry.err = err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

endmodule

FILE: src/pdf_queue.sv
// ----------------------------------------------------------------------------
// pdf_queue
// short fifo of converted values between front and back
// ----------------------------------------------------------------------------
module pdf_queue
    import pdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  pdf_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pdf_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pdf_entry_t       slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/pdf_back.sv
// ----------------------------------------------------------------------------
// pdf_back
// emits the padded field one character a word, or the single error word
// ----------------------------------------------------------------------------
module pdf_back
    import pdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  pdf_entry_t            pop_entry,
    input  logic [WIDTH_W-1:0]    width,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser
);

    back_state_t       state_reg, state_next;
    pdf_entry_t        entry_reg;
    logic [WIDTH_W-1:0] pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_err_reg, out_err_next;
    logic [3:0]        digit;
    logic              advance;
    logic              finish;

    assign advance = (state_reg == B_RUN) && (!out_valid_reg || m_axis_tready);
    assign finish  = advance && (entry_reg.err || pos_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (finish)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop_ready = 1'b1;
            default: pop_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        digit = 4'd0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (pos_reg == WIDTH_W'(i))
            begin
                digit = entry_reg.bcd[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (state_reg == B_IDLE && pop_valid)
        begin
            pos_next = width - WIDTH_W'(1);
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_err_next   = entry_reg.err;
            out_last_next  = entry_reg.err || pos_reg == '0;
            out_char_next  = entry_reg.err ? '0 : CHAR_ZERO + CHAR_W'(digit);
            pos_next       = pos_reg - WIDTH_W'(1);
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            entry_reg <= pop_entry;
        end
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

endmodule

FILE: tb/sv/padded_decimal_formatter_tb.sv
// ----------------------------------------------------------------------------
// padded_decimal_formatter_tb
// self-checking bench: values go in on the slave stream, each one is turned
// into its zero-padded decimal field by a local formatter and every character
// word on the master stream is checked against it, over a range of widths
// ----------------------------------------------------------------------------
module padded_decimal_formatter_tb;
    import pdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              too_wide;
    } char_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [WIDTH_W-1:0]    cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // digit_char, zero fill
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;   // too_wide

    logic [IN_DATA_W-1:0]  pending_values[$];
    char_word_t            expected_words[$];
    char_word_t            head_word;
    logic [WIDTH_W-1:0]    field_width = PAD_WIDTH_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int values_sent = 0;
    int words_seen = 0;
    int overflow_seen = 0;
    int widths_used = 1;
    int fault_count = 0;

    padded_decimal_formatter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] ten_power(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // expected character words for one value at the current field width
    function automatic void format_padded(input logic [63:0] value);
        logic [3:0]  digs[BCD_DIGITS];
        logic [63:0] rest;
        int          nd;
        int          width;
        char_word_t  w;
        rest = value;
        nd = 0;
        do
        begin
            digs[nd] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            nd++;
        end
        while (rest != 0 && nd < BCD_DIGITS);
        width = (int'(field_width) > RESULT_LIMIT) ? RESULT_LIMIT : int'(field_width);
        if (nd > width)
        begin
            w.ch = '0;
            w.last = 1'b1;
            w.too_wide = 1'b1;
            expected_words.push_back(w);
        end
        else
        begin
            for (int k = 0; k < width; k++)
            begin
                w.ch = (k < width - nd) ? CHAR_ZERO
                                        : CHAR_ZERO + CHAR_W'(digs[width - 1 - k]);
                w.last = (k == width - 1);
                w.too_wide = 1'b0;
                expected_words.push_back(w);
            end
        end
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] rnd;
        int          d;
        int          sel;
        rnd = {$urandom, $urandom};
        sel = $urandom_range(9);
        if (sel <= 5)
        begin
            // value with a chosen number of digits
            d = $urandom_range(1, 20);
            lo = (d == 1) ? 64'd0 : ten_power(d - 1);
            hi = (d == 20) ? 64'hFFFF_FFFF_FFFF_FFFF : ten_power(d) - 64'd1;
            return lo + rnd % (hi - lo + 64'd1);
        end
        else if (sel == 7)
            return ten_power($urandom_range(19)) - 64'($urandom_range(1));
        else if (sel == 8)
            return 64'($urandom_range(99));
        return rnd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                format_padded(s_axis_tdata);
                values_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_values.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_seen++;
                if (m_axis_tuser)
                    overflow_seen++;
                if (expected_words.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected word: tdata %0d tlast %0b tuser %0b",
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    head_word = expected_words.pop_front();
                    if (m_axis_tdata !== {2'b00, head_word.ch}
                        || m_axis_tlast !== head_word.last
                        || m_axis_tuser !== head_word.too_wide)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch at word %0d: want %0d/%0b/%0b got %0d/%0b/%0b",
                                     words_seen, head_word.ch, head_word.last,
                                     head_word.too_wide, m_axis_tdata, m_axis_tlast,
                                     m_axis_tuser);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        while (pending_values.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_pad_width(input logic [WIDTH_W-1:0] w);
        wait_drained();
        repeat (8) @(negedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        field_width = w;
        widths_used++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [WIDTH_W-1:0] random_widths[9];
        random_widths = '{5'd7, 5'd20, 5'd1, 5'd31, 5'd0, 5'd15, 5'd10, 5'd3, 5'd19};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 47;
        @(negedge clk);

        // reset width of ten
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(64'd9);
        pending_values.push_back(64'd10);
        pending_values.push_back(64'd9999999999);
        pending_values.push_back(64'd10000000000);
        pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'd10000000000000000000);
        pending_values.push_back(64'd9999999999999999999);

        // full twenty-digit field
        set_pad_width(5'd20);
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(64'd10000000000000000000);
        pending_values.push_back(64'd9999999999999999999);

        // zero width, nothing fits
        set_pad_width(5'd0);
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd5);

        // oversized width saturates
        set_pad_width(5'd31);
        pending_values.push_back(64'd0);
        pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);

        set_pad_width(5'd1);
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd9);
        pending_values.push_back(64'd10);

        for (int ph = 0; ph < 9; ph++)
        begin
            set_pad_width(ph == 6 ? 5'($urandom_range(31)) : random_widths[ph]);
            if (ph >= 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (ph >= 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 23;
            end
            for (int n = 0; n < 50; n++)
                pending_values.push_back(pick_value());
        end

        wait_drained();
        repeat (80) @(negedge clk);
        if (expected_words.size() != 0)
        begin
            fault_count++;
            $display("%0d expected words never arrived", expected_words.size());
        end
        $display("sent %0d values, received %0d character words (%0d overflow flags)",
                 values_sent, words_seen, overflow_seen);
        $display("covered %0d field width settings, %0d faults", widths_used, fault_count);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
